[hdl/tdbp_pkg.sv]
// Package for the tile doubling blit planner.
// Holds the default coordinate width and the cap on blits per request.
// No dependencies.
package tdbp_pkg;

  // Default coordinate width; sizes are one bit wider.
  localparam int unsigned CoordBitsDef = 12;

  // Most blits issued for one request.
  localparam int unsigned MaxResults = 26;

  // Width of the blit counter.
  localparam int unsigned CountBits = $clog2(MaxResults);

endpackage

[hdl/tdbp_step.sv]
// Shared doubling step for the tile doubling blit planner.
// Given the filled extent and the area limit, it gives the next copy size,
// the new extent and the destination. Depends on tdbp_pkg for its default.
module tdbp_step #(
  parameter int unsigned COORD_BITS = tdbp_pkg::CoordBitsDef
) (
  input  logic [COORD_BITS:0]   limit_i,
  input  logic [COORD_BITS:0]   done_i,
  input  logic [COORD_BITS-1:0] base_i,
  output logic [COORD_BITS:0]   size_o,
  output logic [COORD_BITS:0]   next_o,
  output logic [COORD_BITS:0]   dst_o,
  output logic                  phase_end_o
);

  logic [COORD_BITS:0] remain;

  // done is always below limit while a phase runs
  assign remain      = limit_i - done_i;
  assign size_o      = (remain > done_i) ? done_i : remain;
  assign next_o      = done_i + size_o;
  assign dst_o       = {1'b0, base_i} + done_i;
  assign phase_end_o = (next_o == limit_i);

endmodule

[hdl/tile_doubling_blit_planner.sv]
// Tile doubling blit planner: takes one request (origin of a drawn tile, the
// area to fill and the tile size) and issues the screen-to-screen blits that
// fill the area by doubling, first across and then down, the last one marked
// with final_copy_o. A request with nothing to copy, or with a zero size,
// issues no blits. One blit leaves per cycle through an output register while
// the output is not stalled, with at most 26 blits per request. A new request
// is taken once the previous one has issued its last blit.
module tile_doubling_blit_planner #(
  parameter int unsigned COORD_BITS = tdbp_pkg::CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] origin_x_i,
  input  logic [COORD_BITS-1:0] origin_y_i,
  input  logic [COORD_BITS:0]   area_width_i,
  input  logic [COORD_BITS:0]   area_height_i,
  input  logic [COORD_BITS:0]   tile_width_i,
  input  logic [COORD_BITS:0]   tile_height_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] copy_src_x_o,
  output logic [COORD_BITS-1:0] copy_src_y_o,
  output logic [COORD_BITS:0]   copy_dst_x_o,
  output logic [COORD_BITS:0]   copy_dst_y_o,
  output logic [COORD_BITS-1:0] copy_w_minus_one_o,
  output logic [COORD_BITS-1:0] copy_h_minus_one_o,
  output logic                  final_copy_o
);

  localparam int unsigned SW = COORD_BITS + 1;
  localparam logic [SW-1:0] SizeLimit = {1'b1, {COORD_BITS{1'b0}}};
  localparam logic [tdbp_pkg::CountBits-1:0] LastCount =
    tdbp_pkg::CountBits'(tdbp_pkg::MaxResults - 1);

  typedef enum logic [1:0] {
    StIdle,
    StHoriz,
    StVert
  } state_e;

  state_e                       state_q;
  logic [COORD_BITS-1:0]        ox_q, oy_q;
  logic [SW-1:0]                aw_q, ah_q, th_q, hc_q, done_q;
  logic                         vert_q;
  logic [tdbp_pkg::CountBits-1:0] count_q;

  logic                         out_valid_q;
  logic [COORD_BITS-1:0]        src_x_q, src_y_q, w_m1_q, h_m1_q;
  logic [SW-1:0]                dst_x_q, dst_y_q;
  logic                         final_q;

  logic [SW-1:0] aw_c, ah_c, tw_c, th_c;
  logic          accept, advance, in_vert, cap_hit, last;
  logic [SW-1:0] step_limit, step_size, step_next, step_dst;
  logic [SW-1:0] copy_w, copy_h;
  logic          step_end;

  // Saturate oversized sizes so every size minus one fits its field
  assign aw_c = (area_width_i  > SizeLimit) ? SizeLimit : area_width_i;
  assign ah_c = (area_height_i > SizeLimit) ? SizeLimit : area_height_i;
  assign tw_c = (tile_width_i  > SizeLimit) ? SizeLimit : tile_width_i;
  assign th_c = (tile_height_i > SizeLimit) ? SizeLimit : tile_height_i;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign advance    = (state_q != StIdle) && (!out_valid_q || !out_stall_i);
  assign in_vert    = (state_q == StVert);

  assign step_limit = in_vert ? ah_q : aw_q;

  tdbp_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .limit_i     (step_limit),
    .done_i      (done_q),
    .base_i      (in_vert ? oy_q : ox_q),
    .size_o      (step_size),
    .next_o      (step_next),
    .dst_o       (step_dst),
    .phase_end_o (step_end)
  );

  assign cap_hit = (count_q == LastCount);
  assign last    = cap_hit || (step_end && (in_vert || !vert_q));
  assign copy_w  = in_vert ? aw_q : step_size;
  assign copy_h  = in_vert ? step_size : hc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      ox_q        <= '0;
      oy_q        <= '0;
      aw_q        <= '0;
      ah_q        <= '0;
      th_q        <= '0;
      hc_q        <= '0;
      vert_q      <= 1'b0;
      done_q      <= '0;
      src_x_q     <= '0;
      src_y_q     <= '0;
      dst_x_q     <= '0;
      dst_y_q     <= '0;
      w_m1_q      <= '0;
      h_m1_q      <= '0;
      final_q     <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (accept) begin
            count_q <= '0;
            if (aw_c == '0 || ah_c == '0 || tw_c == '0 || th_c == '0) begin
              state_q <= StIdle;
            end else if (tw_c < aw_c) begin
              state_q <= StHoriz;
            end else if (th_c < ah_c) begin
              state_q <= StVert;
            end else begin
              state_q <= StIdle;
            end
          end
        end
        StHoriz, StVert: begin
          if (advance) begin
            count_q <= count_q + 1'b1;
            if (cap_hit) begin
              state_q <= StIdle;
            end else if (step_end) begin
              state_q <= (!in_vert && vert_q) ? StVert : StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase

      // Request and output payload
      if (accept) begin
        ox_q   <= origin_x_i;
        oy_q   <= origin_y_i;
        aw_q   <= aw_c;
        ah_q   <= ah_c;
        th_q   <= th_c;
        hc_q   <= (th_c > ah_c) ? ah_c : th_c;
        vert_q <= (th_c < ah_c);
        done_q <= (tw_c < aw_c) ? tw_c : th_c;
      end else if (advance) begin
        // switch to the vertical extent at the end of the horizontal phase
        done_q <= (step_end && !in_vert) ? th_q : step_next;
      end

      if (advance) begin
        src_x_q <= ox_q;
        src_y_q <= oy_q;
        dst_x_q <= in_vert ? {1'b0, ox_q} : step_dst;
        dst_y_q <= in_vert ? step_dst : {1'b0, oy_q};
        w_m1_q  <= COORD_BITS'(copy_w - 1'b1);
        h_m1_q  <= COORD_BITS'(copy_h - 1'b1);
        final_q <= last;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign copy_src_x_o       = src_x_q;
  assign copy_src_y_o       = src_y_q;
  assign copy_dst_x_o       = dst_x_q;
  assign copy_dst_y_o       = dst_y_q;
  assign copy_w_minus_one_o = w_m1_q;
  assign copy_h_minus_one_o = h_m1_q;
  assign final_copy_o       = final_q;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench for tile_doubling_blit_planner: sends fill requests, works out the
// doubling blits each one should issue and checks every blit in order.
// Depends on tdbp_pkg and the planner RTL.

module tb;

  localparam int unsigned CB = tdbp_pkg::CoordBitsDef;
  localparam int unsigned DW = CB + 1;
  localparam int unsigned SizeMax = 1 << CB;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned LongHold = 200;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned TailCycles = 32;

  typedef struct packed {
    logic [CB-1:0] ox;
    logic [CB-1:0] oy;
    logic [CB:0]   aw;
    logic [CB:0]   ah;
    logic [CB:0]   tw;
    logic [CB:0]   th;
  } fill_req_t;

  typedef struct packed {
    logic [CB-1:0] src_x;
    logic [CB-1:0] src_y;
    logic [CB:0]   dst_x;
    logic [CB:0]   dst_y;
    logic [CB-1:0] w_m1;
    logic [CB-1:0] h_m1;
    logic          last;
  } blit_t;

  class blit_plan_board;
    blit_t       pending_blits[$];
    int unsigned mismatch_count;

    static function int unsigned clamp_size(logic [CB:0] v);
      return (32'(v) > SizeMax) ? SizeMax : 32'(v);
    endfunction

    static function blit_t make_blit(fill_req_t r, int unsigned dx, int unsigned dy,
                                     int unsigned w, int unsigned h);
      blit_t b;
      b.src_x = r.ox;
      b.src_y = r.oy;
      b.dst_x = DW'(dx);
      b.dst_y = DW'(dy);
      b.w_m1  = CB'(w - 1);
      b.h_m1  = CB'(h - 1);
      b.last  = 1'b0;
      return b;
    endfunction

    // Plan the doubling blits for one accepted request and queue them.
    function void add_request(fill_req_t r);
      int unsigned aw, ah, tw, th, done, n, hc;
      blit_t plan[$];
      aw = clamp_size(r.aw);
      ah = clamp_size(r.ah);
      tw = clamp_size(r.tw);
      th = clamp_size(r.th);
      if (aw == 0 || ah == 0 || tw == 0 || th == 0) return;
      if (tw < aw) begin
        hc = (th > ah) ? ah : th;
        done = tw;
        while (done < aw && plan.size() < tdbp_pkg::MaxResults) begin
          n = (aw - done > done) ? done : aw - done;
          plan.push_back(make_blit(r, r.ox + done, r.oy, n, hc));
          done += n;
        end
      end
      if (th < ah) begin
        done = th;
        while (done < ah && plan.size() < tdbp_pkg::MaxResults) begin
          n = (ah - done > done) ? done : ah - done;
          plan.push_back(make_blit(r, r.ox, r.oy + done, aw, n));
          done += n;
        end
      end
      if (plan.size() > 0) plan[plan.size() - 1].last = 1'b1;
      foreach (plan[i]) pending_blits.push_back(plan[i]);
    endfunction

    function void report_field(string name, logic [CB:0] want, logic [CB:0] got);
      if (want !== got) begin
        mismatch_count++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_blit(blit_t got);
      blit_t want;
      if (pending_blits.size() == 0) begin
        mismatch_count++;
        $display("%0t: blit expected none, got dst (%0d,%0d)", $time, got.dst_x, got.dst_y);
        return;
      end
      want = pending_blits.pop_front();
      report_field("copy_src_x", DW'(want.src_x), DW'(got.src_x));
      report_field("copy_src_y", DW'(want.src_y), DW'(got.src_y));
      report_field("copy_dst_x", want.dst_x, got.dst_x);
      report_field("copy_dst_y", want.dst_y, got.dst_y);
      report_field("copy_w_minus_one", DW'(want.w_m1), DW'(got.w_m1));
      report_field("copy_h_minus_one", DW'(want.h_m1), DW'(got.h_m1));
      report_field("final_copy", DW'(want.last), DW'(got.last));
    endfunction

    function int pending();
      return pending_blits.size();
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  logic [CB-1:0] origin_x_i = '0;
  logic [CB-1:0] origin_y_i = '0;
  logic [CB:0]   area_width_i = '0;
  logic [CB:0]   area_height_i = '0;
  logic [CB:0]   tile_width_i = '0;
  logic [CB:0]   tile_height_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic [CB-1:0] copy_src_x_o;
  logic [CB-1:0] copy_src_y_o;
  logic [CB:0]   copy_dst_x_o;
  logic [CB:0]   copy_dst_y_o;
  logic [CB-1:0] copy_w_minus_one_o;
  logic [CB-1:0] copy_h_minus_one_o;
  logic          final_copy_o;

  blit_plan_board board = new;
  bit             idle_on = 1'b1;
  bit             hold_off_req = 1'b0;
  int unsigned    quiet_cycles = 0;

  tile_doubling_blit_planner #(.COORD_BITS(CB)) DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_request(fill_req_t r);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    origin_x_i    <= r.ox;
    origin_y_i    <= r.oy;
    area_width_i  <= r.aw;
    area_height_i <= r.ah;
    tile_width_i  <= r.tw;
    tile_height_i <= r.th;
    do @(posedge clk_i); while (in_stall_o);
    board.add_request(r);
  endtask

  // Drop valid, wait for every queued blit, then let the block settle.
  task automatic wait_drained(int unsigned settle);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  function automatic fill_req_t make_req(int unsigned ox, int unsigned oy, int unsigned aw,
                                         int unsigned ah, int unsigned tw, int unsigned th);
    fill_req_t r;
    r.ox = CB'(ox);
    r.oy = CB'(oy);
    r.aw = DW'(aw);
    r.ah = DW'(ah);
    r.tw = DW'(tw);
    r.th = DW'(th);
    return r;
  endfunction

  // Mostly small sizes, some up to the full range, a few zero or oversized.
  function automatic logic [CB:0] rand_size();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return DW'($urandom_range(SizeMax + 1, (1 << DW) - 1));
      2, 3: return DW'($urandom_range(1, SizeMax));
      default: return DW'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic fill_req_t rand_req();
    fill_req_t r;
    r.ox = CB'($urandom);
    r.oy = CB'($urandom);
    r.aw = rand_size();
    r.ah = rand_size();
    // keep the tile inside the area most of the time so the doubling runs
    if (r.aw inside {[1:SizeMax]} && $urandom_range(0, 4) != 0)
      r.tw = DW'($urandom_range(1, r.aw));
    else
      r.tw = rand_size();
    if (r.ah inside {[1:SizeMax]} && $urandom_range(0, 4) != 0)
      r.th = DW'($urandom_range(1, r.ah));
    else
      r.th = rand_size();
    return r;
  endfunction

  task automatic run_random(int unsigned count);
    repeat (count) send_request(rand_req());
  endtask

  // Blit receiver: stall a random number of cycles before each item.
  initial begin
    int unsigned stall_len;
    blit_t       got;
    wait (rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_len = LongHold;
      end else begin
        stall_len = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got = {copy_src_x_o, copy_src_y_o, copy_dst_x_o, copy_dst_y_o,
             copy_w_minus_one_o, copy_h_minus_one_o, final_copy_o};
      board.check_blit(got);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // nothing to copy, and every size zero in turn
    send_request(make_req(0, 0, 1, 1, 1, 1));
    send_request(make_req(10, 20, 64, 48, 64, 48));
    send_request(make_req(100, 100, 50, 40, 80, 60));
    send_request(make_req(5, 5, 0, 30, 4, 4));
    send_request(make_req(5, 5, 30, 0, 4, 4));
    send_request(make_req(5, 5, 30, 30, 0, 4));
    send_request(make_req(5, 5, 30, 30, 4, 0));
    // longest runs, at both ends of the origin range
    send_request(make_req(4095, 4095, 4096, 4096, 1, 1));
    send_request(make_req(0, 0, 8191, 8191, 1, 1));
    // oversized sizes saturate
    send_request(make_req(1, 2, 5000, 3, 8191, 1));
    send_request(make_req(2048, 1024, 4097, 2, 4096, 1));
    // one phase only, clipped height, ragged remainders
    send_request(make_req(7, 9, 100, 10, 3, 10));
    send_request(make_req(7, 9, 10, 100, 10, 3));
    send_request(make_req(30, 40, 50, 5, 7, 9));
    send_request(make_req(0, 4095, 1000, 777, 3, 5));
    send_request(make_req(4095, 0, 4096, 4096, 4095, 4095));
    send_request(make_req(12'h555, 12'hAAA, 13'h0AAA, 13'h1555, 13'h0555, 13'h00AA));
    wait_drained(SettleCycles);

    run_random(70);
    // hold the next request back until every blit is in
    wait_drained(SettleCycles);

    // back-to-back requests against a long receiver hold
    idle_on = 1'b0;
    hold_off_req = 1'b1;
    run_random(60);
    idle_on = 1'b1;
    run_random(70);
    wait_drained(TailCycles);

    if (board.mismatch_count == 0 && board.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
hdl/tdbp_pkg.sv
hdl/tdbp_step.sv
hdl/tile_doubling_blit_planner.sv
tb/sv/tb.sv
